### hdl/trial_division_prime_test_core_macros.svh
// Assertion macros used by the checker of the prime test core.
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define TDPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define TDPT_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tdpt_pkg.sv
package tdpt_pkg;

  typedef logic [1:0] job_kind_t;

  localparam job_kind_t KIND_NOT_PRIME = 2'd0;
  localparam job_kind_t KIND_PRIME     = 2'd1;
  localparam job_kind_t KIND_TEST      = 2'd2;

endpackage

### hdl/trial_division_prime_test_core.sv
// One item is worked at a time. Values settled by classification (below two, two, even) go from
// the job queue through the idle and push states to the result queue. Odd values try odd divisors
// from three while the square is at most the value; each takes a check, a bit-serial restoring
// remainder pass over VALUE_WIDTH bits and an eval. Worst case at 32 bits: about 23170 divisors.
// Reset is synchronous and active low; it empties both queues and idles the divider.
module trial_division_prime_test_core
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] in_candidate_value,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_prime_flag
);

  logic                   job_pop;
  logic                   job_empty;
  job_kind_t              job_kind;
  logic [VALUE_WIDTH-1:0] job_value;

  tdpt_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .value    ($unsigned(in_candidate_value)),
    .job_pop  (job_pop),
    .job_empty(job_empty),
    .job_kind (job_kind),
    .job_value(job_value)
  );

  tdpt_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_kind  (job_kind),
    .job_value (job_value),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .prime_flag(out_prime_flag)
  );

endmodule

### hdl/tdpt_fifo.sv
module tdpt_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             wr_do, rd_do;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_do   = wr_en && !full;
  assign rd_do   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_do) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_do) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_do, rd_do})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_do) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/tdpt_front.sv
module tdpt_front
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   job_pop,
  output logic                   job_empty,
  output job_kind_t              job_kind,
  output logic [VALUE_WIDTH-1:0] job_value
);

  localparam int JW = VALUE_WIDTH + $bits(job_kind_t);

  job_kind_t     kind;
  logic [JW-1:0] job_wr;
  logic [JW-1:0] job_rd;

  // Negative values, zero, one and even values other than two are settled here.
  always_comb begin
    if (value[VALUE_WIDTH-1] || (value <= VALUE_WIDTH'(1))) begin
      kind = KIND_NOT_PRIME;
    end else if (value == VALUE_WIDTH'(2)) begin
      kind = KIND_PRIME;
    end else if (!value[0]) begin
      kind = KIND_NOT_PRIME;
    end else begin
      kind = KIND_TEST;
    end
  end

  assign job_wr    = {kind, value};
  assign job_kind  = job_rd[JW-1:VALUE_WIDTH];
  assign job_value = job_rd[VALUE_WIDTH-1:0];

  tdpt_fifo #(
    .WIDTH(JW),
    .DEPTH(2)
  ) u_job_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(job_wr),
    .rd_en  (job_pop),
    .rd_data(job_rd),
    .full   (full),
    .empty  (job_empty)
  );

endmodule

### hdl/tdpt_back.sv
module tdpt_back
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_empty,
  input  job_kind_t              job_kind,
  input  logic [VALUE_WIDTH-1:0] job_value,
  output logic                   job_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic                   prime_flag
);

  localparam int DW = VALUE_WIDTH / 2 + 1;
  localparam int SW = VALUE_WIDTH + 1;
  localparam int BW = $clog2(VALUE_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [DW-1:0]          div_r, div_nxt;
  logic [SW-1:0]          sq_r, sq_nxt;
  logic [DW-1:0]          rem_r, rem_nxt;
  logic [BW-1:0]          bit_r, bit_nxt;
  logic                   flag_r, flag_nxt;
  logic [DW:0]            shifted;
  logic                   res_full;
  logic                   res_push;

  assign shifted  = {rem_r, value_r[bit_r]};
  assign job_pop  = (state_r == ST_IDLE) && !job_empty;
  assign res_push = (state_r == ST_PUSH) && !res_full;

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    flag_nxt  = flag_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          if (job_kind == KIND_TEST) begin
            value_nxt = job_value;
            div_nxt   = DW'(3);
            sq_nxt    = SW'(9);
            state_nxt = ST_CHECK;
          end else begin
            flag_nxt  = (job_kind == KIND_PRIME);
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > {1'b0, value_r}) begin
          flag_nxt  = 1'b1;
          state_nxt = ST_PUSH;
        end else begin
          rem_nxt   = '0;
          bit_nxt   = BW'(VALUE_WIDTH - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (shifted >= {1'b0, div_r}) begin
          rem_nxt = DW'(shifted - {1'b0, div_r});
        end else begin
          rem_nxt = shifted[DW-1:0];
        end
        if (bit_r == '0) begin
          state_nxt = ST_EVAL;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_EVAL: begin
        if (rem_r == '0) begin
          flag_nxt  = 1'b0;
          state_nxt = ST_PUSH;
        end else begin
          div_nxt   = div_r + DW'(2);
          sq_nxt    = sq_r + (SW'(div_r) << 2) + SW'(4);
          state_nxt = ST_CHECK;
        end
      end
      ST_PUSH: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    flag_r  <= flag_nxt;
  end

  tdpt_fifo #(
    .WIDTH(1),
    .DEPTH(2)
  ) u_res_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(flag_r),
    .rd_en  (pop),
    .rd_data(prime_flag),
    .full   (res_full),
    .empty  (empty)
  );

endmodule

### hdl/tdpt_checker.sv
`include "trial_division_prime_test_core_macros.svh"

module tdpt_checker (
  input logic clk,
  input logic rst_n,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic out_prime_flag
);

  logic [3:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 4'((push && !full) ? 1 : 0) - 4'((pop && !empty) ? 1 : 0);
    end
  end

  `TDPT_ASSERT_NEXT_ANY(a_reset_clears, !rst_n, empty && !full, "Queues not empty after reset.")
  `TDPT_ASSERT_SAME(a_no_orphan_result, !empty, pending_r != 4'd0, "Result without a transfer.")
  `TDPT_ASSERT_SAME(a_full_needs_items, full, pending_r >= 4'd2, "Full with too few items.")
  `TDPT_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_prime_flag),
                    "Waiting result changed.")

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (.*);
